>>> rtl/core/ied_pkg.sv
`timescale 1ns / 1ps
// Package for the impact event detector: phase codes, register indexes,
// sample/result/config structs. No dependencies.
package ied_pkg;

    localparam int TIME_W = 32;
    localparam int MAG_W = 16;
    localparam int CNT_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    // product width for the drop test: 16-bit value times a 4-bit constant
    localparam int PROD_W = MAG_W + 4;

    // drop test: dynamic below 7/10 of the trigger level
    localparam logic [3:0] DROP_NUM = 4'd7;
    localparam logic [3:0] DROP_DEN = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_MOVING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CANDIDATE_HOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_GRACE = 3'd6;

    localparam logic [MAG_W-1:0] RST_TRIGGER_LEVEL = 16'd6400;
    localparam logic [MAG_W-1:0] RST_STILL_LEVEL = 16'd512;
    localparam logic [MAG_W-1:0] RST_CANDIDATE_HOLD = 16'd30;
    localparam logic [MAG_W-1:0] RST_CONFIRM_WINDOW = 16'd1500;
    localparam logic [MAG_W-1:0] RST_COOLDOWN = 16'd10000;
    localparam logic [MAG_W-1:0] RST_MOVING_GRACE = 16'd3000;

    typedef enum logic [1:0] {
        PH_ARMED     = 2'd0,
        PH_CANDIDATE = 2'd1,
        PH_CONFIRMED = 2'd2,
        PH_COOLDOWN  = 2'd3
    } t_phase;

    typedef struct packed {
        logic              require_moving;
        logic [MAG_W-1:0]  trigger_level;
        logic [MAG_W-1:0]  still_level;
        logic [MAG_W-1:0]  candidate_hold_ms;
        logic [MAG_W-1:0]  confirm_window_ms;
        logic [MAG_W-1:0]  cooldown_ms;
        logic [MAG_W-1:0]  moving_grace_ms;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [MAG_W-1:0]  accel_mag;
        logic [MAG_W-1:0]  accel_base;
        logic              moving;
        logic              upright;
    } t_sample;

    typedef struct packed {
        logic              crash_seen;
        logic [CNT_W-1:0]  crash_number;
        logic [MAG_W-1:0]  peak_level;
    } t_result;

endpackage

>>> rtl/core/ied_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the impact event detector: sample, result and
// config write channels. Depends on ied_pkg.

interface ied_in_if;
    logic                          valid;
    logic                          ready;
    logic [ied_pkg::TIME_W-1:0]    time_ms;
    logic [ied_pkg::MAG_W-1:0]     accel_mag;
    logic [ied_pkg::MAG_W-1:0]     accel_base;
    logic                          moving;
    logic                          upright;

    modport source (output valid, time_ms, accel_mag, accel_base, moving, upright,
                    input ready);
    modport sink (input valid, time_ms, accel_mag, accel_base, moving, upright,
                  output ready);
endinterface

interface ied_out_if;
    logic                          valid;
    logic                          ready;
    logic                          crash_seen;
    logic [ied_pkg::CNT_W-1:0]     crash_number;
    logic [ied_pkg::MAG_W-1:0]     peak_level;

    modport source (output valid, crash_seen, crash_number, peak_level, input ready);
    modport sink (input valid, crash_seen, crash_number, peak_level, output ready);
endinterface

interface ied_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ied_pkg::CFG_IDX_W-1:0]   index;
    logic [ied_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/ied_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the impact event detector.
// Depends on ied_pkg and ied_cfg_if.
module ied_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ied_cfg_if.sink           i_cfg,
    output ied_pkg::t_cfg     o_cfg
);

    ied_pkg::t_cfg r_cfg;
    logic          wr;

    assign i_cfg.ready = 1'b1;
    assign wr = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.require_moving    <= 1'b1;
            r_cfg.trigger_level     <= ied_pkg::RST_TRIGGER_LEVEL;
            r_cfg.still_level       <= ied_pkg::RST_STILL_LEVEL;
            r_cfg.candidate_hold_ms <= ied_pkg::RST_CANDIDATE_HOLD;
            r_cfg.confirm_window_ms <= ied_pkg::RST_CONFIRM_WINDOW;
            r_cfg.cooldown_ms       <= ied_pkg::RST_COOLDOWN;
            r_cfg.moving_grace_ms   <= ied_pkg::RST_MOVING_GRACE;
        end else if (wr) begin
            unique case (i_cfg.index)
                ied_pkg::CFG_REQUIRE_MOVING: r_cfg.require_moving    <= i_cfg.data[0];
                ied_pkg::CFG_TRIGGER_LEVEL:  r_cfg.trigger_level     <= i_cfg.data;
                ied_pkg::CFG_STILL_LEVEL:    r_cfg.still_level       <= i_cfg.data;
                ied_pkg::CFG_CANDIDATE_HOLD: r_cfg.candidate_hold_ms <= i_cfg.data;
                ied_pkg::CFG_CONFIRM_WINDOW: r_cfg.confirm_window_ms <= i_cfg.data;
                ied_pkg::CFG_COOLDOWN:       r_cfg.cooldown_ms       <= i_cfg.data;
                ied_pkg::CFG_MOVING_GRACE:   r_cfg.moving_grace_ms   <= i_cfg.data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/ied_core.sv
`timescale 1ns / 1ps
// Phase machine and event state of the impact event detector: one sample is
// folded into the state per step. Depends on ied_pkg.
module ied_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ied_pkg::t_cfg     i_cfg,
    input  logic              i_step,
    input  ied_pkg::t_sample  i_sample,
    output ied_pkg::t_result  o_result
);

    ied_pkg::t_phase                r_phase, n_phase;
    logic [ied_pkg::TIME_W-1:0]     r_phase_start, n_phase_start;
    logic [ied_pkg::TIME_W-1:0]     r_last_moving, n_last_moving;
    logic                           r_moving_seen, n_moving_seen;
    logic [ied_pkg::MAG_W-1:0]      r_peak, n_peak;
    logic [ied_pkg::CNT_W-1:0]      r_crash_count, n_crash_count;

    logic [ied_pkg::MAG_W-1:0]      dyn;
    logic [ied_pkg::MAG_W-1:0]      peak_max;
    logic [ied_pkg::TIME_W-1:0]     since_move;
    logic [ied_pkg::TIME_W-1:0]     elapsed;
    logic                           gate_open;
    logic                           drop;
    logic                           crash;
    logic [ied_pkg::PROD_W-1:0]     dyn_x10;
    logic [ied_pkg::PROD_W-1:0]     trig_x7;

    always_comb begin
        dyn = (i_sample.accel_mag >= i_sample.accel_base)
            ? i_sample.accel_mag - i_sample.accel_base
            : i_sample.accel_base - i_sample.accel_mag;
        peak_max   = (dyn > r_peak) ? dyn : r_peak;
        since_move = i_sample.time_ms - r_last_moving;
        elapsed    = i_sample.time_ms - r_phase_start;
        // a moving sample refreshes the timestamp first: distance zero
        gate_open  = i_sample.moving
                   || (r_moving_seen
                       && since_move <= {{(ied_pkg::TIME_W-ied_pkg::MAG_W){1'b0}},
                                         i_cfg.moving_grace_ms});
        dyn_x10 = {{(ied_pkg::PROD_W-ied_pkg::MAG_W){1'b0}}, dyn}
                * {{(ied_pkg::PROD_W-4){1'b0}}, ied_pkg::DROP_DEN};
        trig_x7 = {{(ied_pkg::PROD_W-ied_pkg::MAG_W){1'b0}}, i_cfg.trigger_level}
                * {{(ied_pkg::PROD_W-4){1'b0}}, ied_pkg::DROP_NUM};
        drop    = dyn_x10 < trig_x7;
        crash   = (r_phase == ied_pkg::PH_CONFIRMED)
                && (dyn <= i_cfg.still_level || !i_sample.upright);
    end

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_phase_start = r_phase_start;
        n_peak        = peak_max;
        n_crash_count = r_crash_count;
        n_last_moving = i_sample.moving ? i_sample.time_ms : r_last_moving;
        n_moving_seen = r_moving_seen | i_sample.moving;
        unique case (r_phase)
            ied_pkg::PH_ARMED: begin
                if (i_cfg.require_moving && !gate_open) begin
                    n_peak = dyn;
                end else if (dyn >= i_cfg.trigger_level) begin
                    n_phase       = ied_pkg::PH_CANDIDATE;
                    n_phase_start = i_sample.time_ms;
                    n_peak        = dyn;
                end
            end
            ied_pkg::PH_CANDIDATE: begin
                if (drop) begin
                    n_phase       = ied_pkg::PH_ARMED;
                    n_phase_start = i_sample.time_ms;
                    n_peak        = '0;
                end else if (elapsed >= {{(ied_pkg::TIME_W-ied_pkg::MAG_W){1'b0}},
                                         i_cfg.candidate_hold_ms}) begin
                    n_phase       = ied_pkg::PH_CONFIRMED;
                    n_phase_start = i_sample.time_ms;
                end
            end
            ied_pkg::PH_CONFIRMED: begin
                if (crash) begin
                    n_crash_count = r_crash_count + 1'b1;
                    n_phase       = ied_pkg::PH_COOLDOWN;
                    n_phase_start = i_sample.time_ms;
                end else if (elapsed >= {{(ied_pkg::TIME_W-ied_pkg::MAG_W){1'b0}},
                                         i_cfg.confirm_window_ms}) begin
                    n_phase       = ied_pkg::PH_ARMED;
                    n_phase_start = i_sample.time_ms;
                    n_peak        = '0;
                end
            end
            ied_pkg::PH_COOLDOWN: begin
                if (elapsed >= {{(ied_pkg::TIME_W-ied_pkg::MAG_W){1'b0}},
                                i_cfg.cooldown_ms}) begin
                    n_phase       = ied_pkg::PH_ARMED;
                    n_phase_start = i_sample.time_ms;
                    n_peak        = '0;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_result.crash_seen   = crash;
        o_result.crash_number = crash ? r_crash_count + 1'b1 : '0;
        o_result.peak_level   = crash ? peak_max : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ied_pkg::PH_ARMED;
            r_phase_start <= '0;
            r_last_moving <= '0;
            r_moving_seen <= 1'b0;
            r_peak        <= '0;
            r_crash_count <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_phase_start <= n_phase_start;
            r_last_moving <= n_last_moving;
            r_moving_seen <= n_moving_seen;
            r_peak        <= n_peak;
            r_crash_count <= n_crash_count;
        end
    end

    a_crash_to_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.crash_seen |=> r_phase == ied_pkg::PH_COOLDOWN)
        else $error("crash did not enter cooldown");

    a_count_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.crash_seen |=> r_crash_count == $past(r_crash_count) + 1'b1)
        else $error("crash count did not advance");

    a_count_only_on_crash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && o_result.crash_seen) |=> $stable(r_crash_count))
        else $error("crash count moved without a crash");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_peak) && $stable(r_phase_start))
        else $error("state changed without a sample");

endmodule

>>> rtl/core/impact_event_detector_top.sv
`timescale 1ns / 1ps
// Top level of the impact event detector: sample register, core, result
// register. Depends on ied_pkg, ied_if, ied_cfg_regs and ied_core.
//
//   channel  dir  word                                           handshake
//   i_in     in   time_ms, accel_mag, accel_base, moving, upright valid/ready
//   o_out    out  crash_seen, crash_number, peak_level           valid/ready
//   i_cfg    in   index (3b), data (16b)                         valid/ready
//
// One sample per cycle sustained while the output is not stalled; a sample
// passes through the sample register, then one state update writes its result
// into the result register. Reset is synchronous and clears state and config.
// A stalled output holds its word; the sample register keeps taking words
// while the result register is free or being drained. Config is always ready.
module impact_event_detector_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ied_in_if.sink    i_in,
    ied_out_if.source o_out,
    ied_cfg_if.sink   i_cfg
);

    ied_pkg::t_cfg     cfg;
    ied_pkg::t_sample  r_sample;
    ied_pkg::t_result  result;
    ied_pkg::t_result  r_result;
    logic              r_in_vld;
    logic              r_out_vld;
    logic              step;

    assign step       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || step;

    ied_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ied_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_sample (r_sample),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_sample.time_ms    <= i_in.time_ms;
            r_sample.accel_mag  <= i_in.accel_mag;
            r_sample.accel_base <= i_in.accel_base;
            r_sample.moving     <= i_in.moving;
            r_sample.upright    <= i_in.upright;
        end
        if (step) begin
            r_result <= result;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.crash_seen   = r_result.crash_seen;
    assign o_out.crash_number = r_result.crash_number;
    assign o_out.peak_level   = r_result.peak_level;

endmodule
